// ----- design/rv32ie_pkg.sv -----
// Shared types, opcodes and sizes for the RV32I integer execute core.
// No dependencies; the front end, the back end and the top level import this package.

package rv32ie_pkg;

   // Data store and register file sizes
   localparam int unsigned MEM_DEPTH = 1024;
   localparam int unsigned MEM_AW    = $clog2(MEM_DEPTH);
   localparam int unsigned RF_DEPTH  = 32;
   localparam int unsigned RF_AW     = $clog2(RF_DEPTH);
   localparam int unsigned XLEN      = 32;

   // Queue between front and back
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   // Stream widths
   localparam int unsigned REQ_USER_W = 5;
   localparam int unsigned REQ_DATA_W = 80;
   localparam int unsigned RSP_USED_W = 105;
   localparam int unsigned RSP_DATA_W = 112;
   localparam int unsigned RSP_PAD_W  = RSP_DATA_W - RSP_USED_W;

   // Incoming operation codes
   typedef enum logic [4:0] {
      OP_ADD   = 5'd0,  OP_SUB   = 5'd1,  OP_AND   = 5'd2,  OP_OR    = 5'd3,
      OP_XOR   = 5'd4,  OP_SLT   = 5'd5,  OP_SLTU  = 5'd6,  OP_SLL   = 5'd7,
      OP_SRL   = 5'd8,  OP_SRA   = 5'd9,  OP_ADDI  = 5'd10, OP_ANDI  = 5'd11,
      OP_ORI   = 5'd12, OP_XORI  = 5'd13, OP_SLTI  = 5'd14, OP_SLTIU = 5'd15,
      OP_SLLI  = 5'd16, OP_SRLI  = 5'd17, OP_SRAI  = 5'd18, OP_LUI   = 5'd19,
      OP_AUIPC = 5'd20, OP_SW    = 5'd21, OP_SH    = 5'd22, OP_SB    = 5'd23,
      OP_LW    = 5'd24, OP_LH    = 5'd25, OP_LB    = 5'd26, OP_LBU   = 5'd27,
      OP_LHU   = 5'd28
   } op_type;

   // ALU functions after decode
   typedef enum logic [3:0] {
      ALU_ADD, ALU_SUB, ALU_AND, ALU_OR, ALU_XOR,
      ALU_SLT, ALU_SLTU, ALU_SLL, ALU_SRL, ALU_SRA
   } alu_op_type;

   // Instruction class seen by the back end
   typedef enum logic [2:0] {
      CLS_NOP, CLS_ALU, CLS_UPPER, CLS_STORE, CLS_LOAD
   } class_type;

   // Memory access size
   typedef enum logic [1:0] {
      SIZE_WORD, SIZE_HALF, SIZE_BYTE
   } size_type;

   // Result status codes
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_UNWRITTEN = 2'd1,
      ST_RANGE     = 2'd2
   } status_type;

   // Back-end sequencer states
   typedef enum logic [2:0] {
      BS_CLEAR, BS_IDLE, BS_EXEC, BS_MEM, BS_LOAD, BS_DONE
   } back_state_type;

   // Decoded item held in the queue
   typedef struct packed {
      class_type          cls;
      alu_op_type         alu_op;
      logic               use_imm;
      size_type           size;
      logic               is_unsigned;
      logic [RF_AW-1:0]   rd;
      logic [RF_AW-1:0]   rs1;
      logic [RF_AW-1:0]   rs2;
      logic [XLEN-1:0]    imm;
      logic [XLEN-1:0]    pc;
   } item_type;

   // Queue head towards the back end
   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_out_type;

   // Back-end control towards the front end
   typedef struct packed {
      logic pop;
      logic clearing;
   } back_ctl_type;

endpackage

// ----- design/rv32ie_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module rv32ie_ram #(
   parameter int unsigned  WIDTH = 32,
   parameter int unsigned  DEPTH = 32,
   localparam int unsigned AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/rv32ie_front.sv -----
// Front end: accepts request items, decodes them and queues them for the back end.
// Depends on rv32ie_pkg.

module rv32ie_front
   import rv32ie_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [REQ_USER_W-1:0] req_tuser,
   input  back_ctl_type          back_ctl,
   output queue_out_type         queue_out
);

   op_type                op;
   item_type              dec_item;
   logic                  push;
   logic                  full;

   item_type              q_mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]   count_ff, count_in;

   // Classify the incoming item
   always_comb begin
      op                   = op_type'(req_tuser);
      dec_item.cls         = CLS_NOP;
      dec_item.alu_op      = ALU_ADD;
      dec_item.use_imm     = 1'b0;
      dec_item.size        = SIZE_WORD;
      dec_item.is_unsigned = 1'b0;
      dec_item.rd          = req_tdata[4:0];
      dec_item.rs1         = req_tdata[9:5];
      dec_item.rs2         = req_tdata[14:10];
      dec_item.imm         = req_tdata[46:15];
      dec_item.pc          = req_tdata[78:47];
      unique case (op) inside
         OP_ADD:   begin dec_item.cls = CLS_ALU; dec_item.alu_op = ALU_ADD;  end
         OP_SUB:   begin dec_item.cls = CLS_ALU; dec_item.alu_op = ALU_SUB;  end
         OP_AND:   begin dec_item.cls = CLS_ALU; dec_item.alu_op = ALU_AND;  end
         OP_OR:    begin dec_item.cls = CLS_ALU; dec_item.alu_op = ALU_OR;   end
         OP_XOR:   begin dec_item.cls = CLS_ALU; dec_item.alu_op = ALU_XOR;  end
         OP_SLT:   begin dec_item.cls = CLS_ALU; dec_item.alu_op = ALU_SLT;  end
         OP_SLTU:  begin dec_item.cls = CLS_ALU; dec_item.alu_op = ALU_SLTU; end
         OP_SLL:   begin dec_item.cls = CLS_ALU; dec_item.alu_op = ALU_SLL;  end
         OP_SRL:   begin dec_item.cls = CLS_ALU; dec_item.alu_op = ALU_SRL;  end
         OP_SRA:   begin dec_item.cls = CLS_ALU; dec_item.alu_op = ALU_SRA;  end
         OP_ADDI: begin
            dec_item.cls = CLS_ALU; dec_item.alu_op = ALU_ADD;  dec_item.use_imm = 1'b1;
         end
         OP_ANDI: begin
            dec_item.cls = CLS_ALU; dec_item.alu_op = ALU_AND;  dec_item.use_imm = 1'b1;
         end
         OP_ORI: begin
            dec_item.cls = CLS_ALU; dec_item.alu_op = ALU_OR;   dec_item.use_imm = 1'b1;
         end
         OP_XORI: begin
            dec_item.cls = CLS_ALU; dec_item.alu_op = ALU_XOR;  dec_item.use_imm = 1'b1;
         end
         OP_SLTI: begin
            dec_item.cls = CLS_ALU; dec_item.alu_op = ALU_SLT;  dec_item.use_imm = 1'b1;
         end
         OP_SLTIU: begin
            dec_item.cls = CLS_ALU; dec_item.alu_op = ALU_SLTU; dec_item.use_imm = 1'b1;
         end
         OP_SLLI: begin
            dec_item.cls = CLS_ALU; dec_item.alu_op = ALU_SLL;  dec_item.use_imm = 1'b1;
         end
         OP_SRLI: begin
            dec_item.cls = CLS_ALU; dec_item.alu_op = ALU_SRL;  dec_item.use_imm = 1'b1;
         end
         OP_SRAI: begin
            dec_item.cls = CLS_ALU; dec_item.alu_op = ALU_SRA;  dec_item.use_imm = 1'b1;
         end
         // LUI is AUIPC with a zero base
         OP_LUI: begin
            dec_item.cls       = CLS_UPPER;
            dec_item.imm[11:0] = '0;
            dec_item.pc        = '0;
         end
         OP_AUIPC: begin
            dec_item.cls       = CLS_UPPER;
            dec_item.imm[11:0] = '0;
         end
         OP_SW: begin dec_item.cls = CLS_STORE; dec_item.size = SIZE_WORD; end
         OP_SH: begin dec_item.cls = CLS_STORE; dec_item.size = SIZE_HALF; end
         OP_SB: begin dec_item.cls = CLS_STORE; dec_item.size = SIZE_BYTE; end
         OP_LW: begin dec_item.cls = CLS_LOAD;  dec_item.size = SIZE_WORD; end
         OP_LH: begin dec_item.cls = CLS_LOAD;  dec_item.size = SIZE_HALF; end
         OP_LB: begin dec_item.cls = CLS_LOAD;  dec_item.size = SIZE_BYTE; end
         OP_LBU: begin
            dec_item.cls = CLS_LOAD; dec_item.size = SIZE_BYTE; dec_item.is_unsigned = 1'b1;
         end
         OP_LHU: begin
            dec_item.cls = CLS_LOAD; dec_item.size = SIZE_HALF; dec_item.is_unsigned = 1'b1;
         end
         default: dec_item.cls = CLS_NOP;
      endcase
   end

   // Accept while there is room and the store clearing pass is over
   assign full       = (count_ff == QUEUE_CW'(QUEUE_DEPTH));
   assign req_tready = !full && !back_ctl.clearing;
   assign push       = req_tvalid && req_tready;

   // Advance queue pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (back_ctl.pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, back_ctl.pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Hold queued items
   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= dec_item;
      end
   end

   assign queue_out.valid = (count_ff != '0);
   assign queue_out.item  = q_mem_ff[rd_ptr_ff];

endmodule

// ----- design/rv32ie_back.sv -----
// Back end: runs queued items against the register file and the data store.
// Depends on rv32ie_pkg and rv32ie_ram.

module rv32ie_back
   import rv32ie_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  queue_out_type         queue_out,
   output back_ctl_type          back_ctl,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   function automatic logic [XLEN-1:0] alu_calc(alu_op_type op, logic [XLEN-1:0] a,
                                                 logic [XLEN-1:0] b);
      logic [4:0]      sh;
      logic [XLEN-1:0] r;
      sh = b[4:0];
      unique case (op)
         ALU_ADD:  r = a + b;
         ALU_SUB:  r = a - b;
         ALU_AND:  r = a & b;
         ALU_OR:   r = a | b;
         ALU_XOR:  r = a ^ b;
         ALU_SLT:  r = {{(XLEN-1){1'b0}}, ($signed(a) < $signed(b))};
         ALU_SLTU: r = {{(XLEN-1){1'b0}}, (a < b)};
         ALU_SLL:  r = a << sh;
         ALU_SRL:  r = a >> sh;
         ALU_SRA:  r = $unsigned($signed(a) >>> sh);
         default:  r = '0;
      endcase
      return r;
   endfunction

   back_state_type   state_ff, state_in;
   logic [MEM_AW-1:0] clr_cnt_ff, clr_cnt_in;
   logic [RF_DEPTH-1:0] rf_valid_ff, rf_valid_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   item_type         cur_ff;
   logic             wr_ff;
   logic [XLEN-1:0]  val_ff;
   logic             mw_ff;
   logic [XLEN-1:0]  maddr_ff;
   logic [XLEN-1:0]  mval_ff;
   logic [XLEN-1:0]  sdata_ff;
   status_type       status_ff;

   logic             pop;
   logic             out_free;
   logic             out_load;
   logic             rf_wr_en;
   logic             mem_wr_en;
   logic             mem_rd_en;
   logic             in_range;
   logic             is_mem;
   logic             fin_wr;
   logic             vram_wr_en;
   logic [MEM_AW-1:0] vram_wr_addr;
   logic             vram_wr_data;
   logic [XLEN-1:0]  rf_rd1, rf_rd2;
   logic [XLEN-1:0]  op_a, op_b_reg, op_b;
   logic [XLEN-1:0]  dram_rd;
   logic             vram_rd;
   logic [XLEN-1:0]  load_val;

   // Register file: two copies give two read ports
   rv32ie_ram #(.WIDTH(XLEN), .DEPTH(RF_DEPTH)) u_rf_a (
      .clock   (clock),
      .wr_en   (rf_wr_en),
      .wr_addr (cur_ff.rd),
      .wr_data (val_ff),
      .rd_en   (pop),
      .rd_addr (queue_out.item.rs1),
      .rd_data (rf_rd1)
   );

   rv32ie_ram #(.WIDTH(XLEN), .DEPTH(RF_DEPTH)) u_rf_b (
      .clock   (clock),
      .wr_en   (rf_wr_en),
      .wr_addr (cur_ff.rd),
      .wr_data (val_ff),
      .rd_en   (pop),
      .rd_addr (queue_out.item.rs2),
      .rd_data (rf_rd2)
   );

   // Data store words
   rv32ie_ram #(.WIDTH(XLEN), .DEPTH(MEM_DEPTH)) u_data (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (maddr_ff[MEM_AW-1:0]),
      .wr_data (sdata_ff),
      .rd_en   (mem_rd_en),
      .rd_addr (maddr_ff[MEM_AW-1:0]),
      .rd_data (dram_rd)
   );

   // Written marks, swept to zero after reset
   rv32ie_ram #(.WIDTH(1), .DEPTH(MEM_DEPTH)) u_written (
      .clock   (clock),
      .wr_en   (vram_wr_en),
      .wr_addr (vram_wr_addr),
      .wr_data (vram_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (maddr_ff[MEM_AW-1:0]),
      .rd_data (vram_rd)
   );

   // Operands: unwritten registers and x0 read as zero
   assign op_a     = rf_valid_ff[cur_ff.rs1] ? rf_rd1 : '0;
   assign op_b_reg = rf_valid_ff[cur_ff.rs2] ? rf_rd2 : '0;
   assign op_b     = cur_ff.use_imm ? cur_ff.imm : op_b_reg;
   assign is_mem   = (cur_ff.cls == CLS_LOAD) || (cur_ff.cls == CLS_STORE);
   assign in_range = (maddr_ff < XLEN'(MEM_DEPTH));
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign fin_wr   = wr_ff && (cur_ff.rd != '0);

   assign vram_wr_en   = (state_ff == BS_CLEAR) || mem_wr_en;
   assign vram_wr_addr = (state_ff == BS_CLEAR) ? clr_cnt_ff : maddr_ff[MEM_AW-1:0];
   assign vram_wr_data = (state_ff != BS_CLEAR);

   // Extend the loaded word
   always_comb begin
      case (cur_ff.size)
         SIZE_HALF: load_val = cur_ff.is_unsigned ? {16'b0, dram_rd[15:0]}
                                                  : {{16{dram_rd[15]}}, dram_rd[15:0]};
         SIZE_BYTE: load_val = cur_ff.is_unsigned ? {24'b0, dram_rd[7:0]}
                                                  : {{24{dram_rd[7]}}, dram_rd[7:0]};
         default:   load_val = dram_rd;
      endcase
   end

   // Sequencer: next state and strobes
   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      rf_valid_in  = rf_valid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      pop          = 1'b0;
      out_load     = 1'b0;
      rf_wr_en     = 1'b0;
      mem_wr_en    = 1'b0;
      mem_rd_en    = 1'b0;
      unique case (state_ff)
         BS_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == MEM_AW'(MEM_DEPTH - 1)) begin
               state_in = BS_IDLE;
            end
         end
         BS_IDLE: begin
            if (queue_out.valid) begin
               pop      = 1'b1;
               state_in = BS_EXEC;
            end
         end
         BS_EXEC: begin
            state_in = is_mem ? BS_MEM : BS_DONE;
         end
         BS_MEM: begin
            if (!in_range) begin
               state_in = BS_DONE;
            end else if (cur_ff.cls == CLS_STORE) begin
               mem_wr_en = 1'b1;
               state_in  = BS_DONE;
            end else begin
               mem_rd_en = 1'b1;
               state_in  = BS_LOAD;
            end
         end
         BS_LOAD: begin
            state_in = BS_DONE;
         end
         BS_DONE: begin
            if (out_free) begin
               out_load     = 1'b1;
               rsp_valid_in = 1'b1;
               rf_wr_en     = fin_wr;
               if (fin_wr) begin
                  rf_valid_in[cur_ff.rd] = 1'b1;
               end
               state_in = BS_IDLE;
            end
         end
         default: state_in = BS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BS_CLEAR;
         clr_cnt_ff   <= '0;
         rf_valid_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rf_valid_ff  <= rf_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= queue_out.item;
      end
      case (state_ff)
         BS_EXEC: begin
            wr_ff     <= (cur_ff.cls == CLS_ALU) || (cur_ff.cls == CLS_UPPER);
            val_ff    <= (cur_ff.cls == CLS_UPPER) ? cur_ff.pc + cur_ff.imm
                                                   : alu_calc(cur_ff.alu_op, op_a, op_b);
            maddr_ff  <= is_mem ? op_a + {{20{cur_ff.imm[11]}}, cur_ff.imm[11:0]} : '0;
            case (cur_ff.size)
               SIZE_HALF: sdata_ff <= {16'b0, op_b_reg[15:0]};
               SIZE_BYTE: sdata_ff <= {24'b0, op_b_reg[7:0]};
               default:   sdata_ff <= op_b_reg;
            endcase
            mw_ff     <= 1'b0;
            mval_ff   <= '0;
            status_ff <= ST_OK;
         end
         BS_MEM: begin
            if (!in_range) begin
               status_ff <= ST_RANGE;
            end else if (cur_ff.cls == CLS_STORE) begin
               mw_ff   <= 1'b1;
               mval_ff <= sdata_ff;
            end
         end
         BS_LOAD: begin
            if (!vram_rd) begin
               status_ff <= ST_UNWRITTEN;
            end else begin
               mval_ff <= dram_rd;
               val_ff  <= load_val;
               wr_ff   <= 1'b1;
            end
         end
         default: begin
         end
      endcase
      // Pack result, highest field first
      if (out_load) begin
         rsp_data_ff <= {{RSP_PAD_W{1'b0}}, status_ff, mval_ff, maddr_ff, mw_ff,
                         fin_wr ? val_ff : {XLEN{1'b0}},
                         fin_wr ? cur_ff.rd : {RF_AW{1'b0}},
                         fin_wr};
      end
   end

   assign back_ctl.pop      = pop;
   assign back_ctl.clearing = (state_ff == BS_CLEAR);
   assign rsp_tvalid        = rsp_valid_ff;
   assign rsp_tdata         = rsp_data_ff;

endmodule

// ----- design/rv32i_integer_execute_core.sv -----
// Top level of the RV32I integer execute core: front end, queue and back end.
// Depends on rv32ie_pkg, rv32ie_front, rv32ie_back and rv32ie_ram.

// Executes one decoded RV32I instruction per item (ALU, shifts, set-less-than,
// LUI, AUIPC, word/half/byte loads and stores) against a 32-entry register file
// and a MEM_DEPTH-word data store, and returns one result item per instruction.
// After reset the core sweeps the written marks of all MEM_DEPTH store words
// (1024 by default) to zero and holds req_tready low during that pass. A front
// end decodes items into a two-entry queue; the back-end sequencer then steps
// each item from idle through execute to done, with a memory state for loads
// and stores and a further load state for in-range loads, as the register file
// and the data store have registered reads. Results wait in an output register,
// so new items are still queued while the consumer stalls. A load from an
// address never stored to leaves the register file unchanged and reports
// status 1; an address at or beyond MEM_DEPTH reports status 2 and has no effect.

module rv32i_integer_execute_core
   import rv32ie_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // dest_index[4:0], src1_reg[9:5], src2_reg[14:10], immediate[46:15],
   // pc_value[78:47], zero[79]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // req_type[4:0]
   input  logic [REQ_USER_W-1:0] req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // reg_write[0], reg_index[5:1], reg_value[37:6], mem_write[38],
   // mem_address[70:39], mem_value[102:71], status[104:103], zero[111:105]
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   queue_out_type queue_out;
   back_ctl_type  back_ctl;

   rv32ie_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .back_ctl   (back_ctl),
      .queue_out  (queue_out)
   );

   rv32ie_back u_back (
      .clock      (clock),
      .reset      (reset),
      .queue_out  (queue_out),
      .back_ctl   (back_ctl),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ----- dv/tb_rv32i_integer_execute_core.sv -----
// Self-checking testbench for rv32i_integer_execute_core: directed and random instructions
// are checked against an in-bench model of the register file and the word store.
// Depends on rv32ie_pkg and the design files under design/.

module tb_rv32i_integer_execute_core;
   import rv32ie_pkg::*;

   // Codes that the core must treat as no operation
   localparam logic [4:0] FIRST_UNUSED_OP = 5'd29;
   localparam logic [4:0] LAST_UNUSED_OP  = 5'd31;

   // Length of the long receiver hold-off, in cycles
   localparam int HOLD_OFF_CYCLES = 200;
   // Cycles to let pass once nothing is expected any more
   localparam int TAIL_CYCLES     = 20;
   // Number of items after which the random part stops
   localparam int ITEM_TARGET     = 1140;

   // One result item, field by field
   typedef struct packed {
      logic        reg_write;
      logic [4:0]  reg_index;
      logic [31:0] reg_value;
      logic        mem_write;
      logic [31:0] mem_address;
      logic [31:0] mem_value;
      logic [1:0]  status;
   } exec_result_t;

   // Architectural model of the core and the queue of results it still owes
   class execute_predictor;
      logic [31:0]  gpr [32];
      logic [31:0]  word_store [MEM_DEPTH];
      bit           word_written [MEM_DEPTH];
      exec_result_t expected_results [$];
      int           mismatch_count;

      function new();
         foreach (gpr[i]) gpr[i] = '0;
         foreach (word_store[i]) word_store[i] = '0;
         foreach (word_written[i]) word_written[i] = 1'b0;
         mismatch_count = 0;
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

      function logic [31:0] read_reg(logic [4:0] idx);
         return (idx == 5'd0) ? 32'd0 : gpr[idx];
      endfunction

      function logic [31:0] alu_result(alu_op_type fn, logic [31:0] a, logic [31:0] b);
         case (fn)
            ALU_ADD:  return a + b;
            ALU_SUB:  return a - b;
            ALU_AND:  return a & b;
            ALU_OR:   return a | b;
            ALU_XOR:  return a ^ b;
            ALU_SLT:  return {31'd0, $signed(a) < $signed(b)};
            ALU_SLTU: return {31'd0, a < b};
            ALU_SLL:  return a << b[4:0];
            ALU_SRL:  return a >> b[4:0];
            ALU_SRA:  return $unsigned($signed(a) >>> b[4:0]);
            default:  return 32'd0;
         endcase
      endfunction

      // Execute one accepted instruction and queue the result it must give
      function void note_instruction(logic [4:0] code, logic [4:0] rd, logic [4:0] rs1,
                                     logic [4:0] rs2, logic [31:0] imm, logic [31:0] pc);
         logic [31:0]  a;
         logic [31:0]  b;
         logic [31:0]  val;
         logic [31:0]  addr;
         logic [31:0]  mval;
         logic         wr;
         logic         mw;
         status_type   st;
         alu_op_type   fn;
         exec_result_t r;
         a    = read_reg(rs1);
         b    = read_reg(rs2);
         val  = '0;
         addr = '0;
         mval = '0;
         wr   = 1'b0;
         mw   = 1'b0;
         st   = ST_OK;
         case (code)
            OP_ADD, OP_ADDI:   fn = ALU_ADD;
            OP_SUB:            fn = ALU_SUB;
            OP_AND, OP_ANDI:   fn = ALU_AND;
            OP_OR, OP_ORI:     fn = ALU_OR;
            OP_XOR, OP_XORI:   fn = ALU_XOR;
            OP_SLT, OP_SLTI:   fn = ALU_SLT;
            OP_SLTU, OP_SLTIU: fn = ALU_SLTU;
            OP_SLL, OP_SLLI:   fn = ALU_SLL;
            OP_SRL, OP_SRLI:   fn = ALU_SRL;
            OP_SRA, OP_SRAI:   fn = ALU_SRA;
            default:           fn = ALU_ADD;
         endcase

         if (code <= OP_SRA) begin
            wr  = 1'b1;
            val = alu_result(fn, a, b);
         end else if (code <= OP_SRAI) begin
            wr  = 1'b1;
            val = alu_result(fn, a, imm);
         end else if (code == OP_LUI) begin
            wr  = 1'b1;
            val = {imm[31:12], 12'd0};
         end else if (code == OP_AUIPC) begin
            wr  = 1'b1;
            val = pc + {imm[31:12], 12'd0};
         end else if (code <= OP_LHU) begin
            // offset is the low 12 bits of the immediate, sign-extended
            addr = a + {{20{imm[11]}}, imm[11:0]};
            if (addr >= MEM_DEPTH) begin
               st = ST_RANGE;
            end else if (code <= OP_SB) begin
               case (code)
                  OP_SW:   mval = b;
                  OP_SH:   mval = {16'd0, b[15:0]};
                  default: mval = {24'd0, b[7:0]};
               endcase
               word_store[addr]   = mval;
               word_written[addr] = 1'b1;
               mw = 1'b1;
            end else if (!word_written[addr]) begin
               st = ST_UNWRITTEN;
            end else begin
               mval = word_store[addr];
               wr   = 1'b1;
               case (code)
                  OP_LW:   val = mval;
                  OP_LH:   val = {{16{mval[15]}}, mval[15:0]};
                  OP_LB:   val = {{24{mval[7]}}, mval[7:0]};
                  OP_LBU:  val = {24'd0, mval[7:0]};
                  default: val = {16'd0, mval[15:0]};
               endcase
            end
         end

         // x0 never changes; a discarded write reports nothing
         if (wr && rd != 5'd0) begin
            gpr[rd] = val;
         end else begin
            wr  = 1'b0;
            rd  = '0;
            val = '0;
         end

         r.reg_write   = wr;
         r.reg_index   = rd;
         r.reg_value   = val;
         r.mem_write   = mw;
         r.mem_address = addr;
         r.mem_value   = mval;
         r.status      = st;
         expected_results.push_back(r);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            mismatch_count++;
            $display("%0t: %s differs: expected %h, actual %h", $time, name, want, got);
         end
      endfunction

      // Compare one result item with the oldest expectation
      function void check_result(logic [RSP_DATA_W-1:0] word);
         exec_result_t want;
         if (expected_results.size() == 0) begin
            mismatch_count++;
            $display("%0t: result with none expected: expected nothing, actual %h",
                     $time, word);
            return;
         end
         want = expected_results.pop_front();
         compare_field("reg_write", 32'(want.reg_write), 32'(word[0]));
         compare_field("reg_index", 32'(want.reg_index), 32'(word[5:1]));
         compare_field("reg_value", want.reg_value, word[37:6]);
         compare_field("mem_write", 32'(want.mem_write), 32'(word[38]));
         compare_field("mem_address", want.mem_address, word[70:39]);
         compare_field("mem_value", want.mem_value, word[102:71]);
         compare_field("status", 32'(want.status), 32'(word[104:103]));
      endfunction
   endclass

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [REQ_USER_W-1:0] req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   execute_predictor predictor = new;

   int items_sent  = 0;
   int burst_left  = 0;
   bit hold_request = 1'b0;

   rv32i_integer_execute_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Offer one instruction, hold it until taken, then pace the next burst
   task automatic send_instr(input logic [4:0] code, input logic [4:0] rd,
                             input logic [4:0] rs1, input logic [4:0] rs2,
                             input logic [31:0] imm, input logic [31:0] pc);
      int gap;
      req_tuser  <= code;
      req_tdata  <= {1'b0, pc, imm, rs2, rs1, rd};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      predictor.note_instruction(code, rd, rs1, rs2, imm, pc);
      items_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = $urandom_range(1, 12);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
         // long bursts give stretches with no idling at all
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(0, 12);
      end
   endtask

   // Stop offering and wait until every expected result has come back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (predictor.pending() != 0);
   endtask

   // Give-up time far beyond the slowest correct run
   initial begin
      #5000000;
      $display("Mismatches found");
      $finish;
   end

   // Receiver: check each result item and stall on a shifting pattern
   initial begin
      logic [15:0] ready_pattern;
      int          pattern_pos;
      int          pattern_life;
      int          hold_left;
      ready_pattern = '1;
      pattern_pos   = 0;
      pattern_life  = 0;
      hold_left     = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) predictor.check_result(rsp_tdata);
         if (hold_request && hold_left == 0) begin
            hold_left    = HOLD_OFF_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            if (pattern_life == 0) begin
               case ($urandom_range(0, 3))
                  0:       ready_pattern = '1;
                  1:       ready_pattern = 16'($urandom);
                  2:       ready_pattern = 16'($urandom | $urandom);
                  default: ready_pattern = 16'($urandom & $urandom);
               endcase
               ready_pattern[0] = 1'b1;
               pattern_life = $urandom_range(16, 128);
            end
            pattern_life--;
            rsp_tready  <= ready_pattern[pattern_pos];
            pattern_pos = (pattern_pos + 1) % 16;
         end
      end
   end

   // Sender: reset, directed instructions, then random instruction streams
   initial begin
      logic [4:0]  code;
      logic [4:0]  rb;
      logic [4:0]  rd;
      logic [31:0] base;
      logic [31:0] imm;
      int          offset;
      int          count;
      bit          held_first;
      bit          held_second;
      bit          paused;
      held_first  = 1'b0;
      held_second = 1'b0;
      paused      = 1'b0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // extreme operands through every ALU operation
      send_instr(OP_ADDI, 5'd1, 5'd0, 5'd0, 32'h7FFF_FFFF, 32'h0);
      send_instr(OP_ADDI, 5'd2, 5'd0, 5'd31, 32'h8000_0000, 32'hFFFF_FFFF);
      send_instr(OP_ADD, 5'd3, 5'd1, 5'd2, 32'h0, 32'h0);
      send_instr(OP_SUB, 5'd4, 5'd2, 5'd1, 32'h0, 32'h0);
      send_instr(OP_AND, 5'd5, 5'd3, 5'd1, 32'h0, 32'h0);
      send_instr(OP_OR, 5'd6, 5'd1, 5'd2, 32'h0, 32'h0);
      send_instr(OP_XOR, 5'd7, 5'd3, 5'd1, 32'h0, 32'h0);
      send_instr(OP_SLT, 5'd8, 5'd2, 5'd1, 32'h0, 32'h0);
      send_instr(OP_SLTU, 5'd9, 5'd2, 5'd1, 32'h0, 32'h0);
      send_instr(OP_SLL, 5'd10, 5'd3, 5'd1, 32'h0, 32'h0);
      send_instr(OP_SRL, 5'd11, 5'd3, 5'd1, 32'h0, 32'h0);
      send_instr(OP_SRA, 5'd12, 5'd2, 5'd1, 32'h0, 32'h0);
      send_instr(OP_ANDI, 5'd13, 5'd3, 5'd0, 32'hF0F0_0F0F, 32'h0);
      send_instr(OP_ORI, 5'd14, 5'd0, 5'd0, 32'hFFFF_FFFF, 32'h0);
      send_instr(OP_XORI, 5'd15, 5'd1, 5'd0, 32'hFFFF_FFFF, 32'h0);
      send_instr(OP_SLTI, 5'd16, 5'd2, 5'd0, 32'h0, 32'h0);
      // unsigned compare against an all-ones immediate
      send_instr(OP_SLTIU, 5'd17, 5'd1, 5'd0, 32'hFFFF_FFFF, 32'h0);
      // shift amounts above 31 keep only their low five bits
      send_instr(OP_SLLI, 5'd18, 5'd3, 5'd0, 32'h0000_0021, 32'h0);
      send_instr(OP_SRLI, 5'd19, 5'd3, 5'd0, 32'hFFFF_FFFF, 32'h0);
      send_instr(OP_SRAI, 5'd20, 5'd2, 5'd0, 32'h0000_003F, 32'h0);
      send_instr(OP_LUI, 5'd21, 5'd0, 5'd0, 32'hFFFF_FFFF, 32'h0);
      // auipc wraps past the top of the address space
      send_instr(OP_AUIPC, 5'd22, 5'd0, 5'd0, 32'h0000_1FFF, 32'hFFFF_FFFF);
      // write to x0 is dropped
      send_instr(OP_ADDI, 5'd0, 5'd3, 5'd0, 32'h5, 32'h0);
      // store sizes, then every load width over them
      send_instr(OP_SW, 5'd0, 5'd0, 5'd3, 32'h0, 32'h0);
      send_instr(OP_SH, 5'd0, 5'd0, 5'd2, 32'hFFFF_F001, 32'h0);
      send_instr(OP_SH, 5'd0, 5'd0, 5'd3, 32'h0000_0002, 32'h0);
      send_instr(OP_SB, 5'd0, 5'd0, 5'd3, 32'h0000_0003, 32'h0);
      send_instr(OP_LW, 5'd24, 5'd0, 5'd0, 32'h0, 32'h0);
      send_instr(OP_LH, 5'd25, 5'd0, 5'd0, 32'h2, 32'h0);
      send_instr(OP_LB, 5'd26, 5'd0, 5'd0, 32'h3, 32'h0);
      send_instr(OP_LBU, 5'd27, 5'd0, 5'd0, 32'h3, 32'h0);
      send_instr(OP_LHU, 5'd28, 5'd0, 5'd0, 32'h2, 32'h0);
      // load from an address beyond the end of the data store
      send_instr(OP_LW, 5'd29, 5'd0, 5'd0, 32'h0000_07FF, 32'h0);
      // negative offset from zero wraps to a huge address
      send_instr(OP_SW, 5'd0, 5'd0, 5'd3, 32'h0000_0FFF, 32'h0);
      // last word in range, then the first beyond it, then the last word again
      send_instr(OP_ADDI, 5'd30, 5'd0, 5'd0, MEM_DEPTH, 32'h0);
      send_instr(OP_SB, 5'd0, 5'd30, 5'd1, 32'h0000_0FFF, 32'h0);
      send_instr(OP_LBU, 5'd31, 5'd30, 5'd0, 32'h0000_0000, 32'h0);
      send_instr(OP_LB, 5'd31, 5'd30, 5'd0, 32'hFFFF_FFFF, 32'h0);
      send_instr(LAST_UNUSED_OP, 5'd31, 5'd31, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      drain_results();

      while (items_sent < ITEM_TARGET) begin
         // long receiver hold-off twice, one full pause of the sender
         if (!held_first && items_sent >= 350) begin
            held_first   = 1'b1;
            hold_request = 1'b1;
         end
         if (!paused && items_sent >= 600) begin
            paused = 1'b1;
            drain_results();
         end
         if (!held_second && items_sent >= 850) begin
            held_second  = 1'b1;
            hold_request = 1'b1;
         end

         case ($urandom_range(0, 99)) inside
            [0:39]: begin
               // register and immediate arithmetic with random content
               code = 5'($urandom_range(int'(OP_ADD), int'(OP_SRAI)));
               send_instr(code, 5'($urandom), 5'($urandom), 5'($urandom), $urandom, $urandom);
            end
            [40:84]: begin
               // set a base register, then a run of loads and stores around it
               rb = 5'($urandom_range(1, 31));
               case ($urandom_range(0, 9))
                  0, 1, 2, 3, 4, 5: base = $urandom_range(0, 31);
                  6, 7:             base = $urandom_range(0, MEM_DEPTH - 1);
                  8:                base = $urandom_range(MEM_DEPTH - 6, MEM_DEPTH + 5);
                  default:          base = $urandom;
               endcase
               send_instr(OP_ADDI, rb, 5'd0, 5'($urandom), base, $urandom);
               count = $urandom_range(1, 6);
               repeat (count) begin
                  code   = 5'($urandom_range(int'(OP_SW), int'(OP_LHU)));
                  offset = $urandom_range(0, 15) - 8;
                  imm    = ($urandom & 32'hFFFF_F000) | (32'(offset) & 32'h0000_0FFF);
                  rd     = 5'($urandom);
                  if (rd == rb) rd = 5'd0;
                  send_instr(code, rd, rb, 5'($urandom), imm, $urandom);
               end
            end
            [85:94]: begin
               code = ($urandom_range(0, 1) == 0) ? OP_LUI : OP_AUIPC;
               send_instr(code, 5'($urandom), 5'($urandom), 5'($urandom), $urandom, $urandom);
            end
            default: begin
               // noise: unused codes or memory access with random everything
               if ($urandom_range(0, 1) == 0)
                  code = 5'($urandom_range(int'(FIRST_UNUSED_OP), int'(LAST_UNUSED_OP)));
               else
                  code = 5'($urandom_range(int'(OP_SW), int'(OP_LHU)));
               send_instr(code, 5'($urandom), 5'($urandom), 5'($urandom), $urandom, $urandom);
            end
         endcase
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (predictor.mismatch_count == 0 && predictor.pending() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
